### src/charge_phase_sequencer_macros.svh
// assertion macros for the charge phase sequencer
`ifndef CHARGE_PHASE_SEQUENCER_MACROS_SVH
`define CHARGE_PHASE_SEQUENCER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, checked on every rising edge outside reset
`define CPS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("charge_phase_sequencer: check failed");
// next-cycle implication
`define CPS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("charge_phase_sequencer: check failed");
`else
`define CPS_ASSERT_IMP(label, ante, cons)
`define CPS_ASSERT_NXT(label, ante, cons)
`endif

`endif

### src/cps_pkg.sv
// shared constants and control types of the charge phase sequencer
package cps_pkg;

  localparam int SlotW   = 3;
  localparam int PhaseW  = 3;
  localparam int ReasonW = 3;
  localparam int ActW    = 2;
  localparam int VerdW   = 2;
  localparam int TickW   = 16;
  localparam int TimeW   = 32;
  localparam int CurW    = 32;
  localparam int CutW    = 31;
  localparam int InDataW  = 152;
  localparam int OutDataW = 16;

  localparam logic [PhaseW-1:0] PH_IDLE  = 3'd0;
  localparam logic [PhaseW-1:0] PH_RAMP  = 3'd1;
  localparam logic [PhaseW-1:0] PH_CC    = 3'd2;
  localparam logic [PhaseW-1:0] PH_CV    = 3'd3;
  localparam logic [PhaseW-1:0] PH_TERM  = 3'd4;
  localparam logic [PhaseW-1:0] PH_DONE  = 3'd5;
  localparam logic [PhaseW-1:0] PH_ABORT = 3'd6;

  localparam logic [ReasonW-1:0] RS_NONE    = 3'd0;
  localparam logic [ReasonW-1:0] RS_TIMEOUT = 3'd1;
  localparam logic [ReasonW-1:0] RS_FAULT   = 3'd2;
  localparam logic [ReasonW-1:0] RS_LOST    = 3'd3;
  localparam logic [ReasonW-1:0] RS_USER    = 3'd4;
  localparam logic [ReasonW-1:0] RS_REFUSED = 3'd5;

  localparam logic [ActW-1:0] ACT_START = 2'd0;
  localparam logic [ActW-1:0] ACT_ABORT = 2'd1;
  localparam logic [ActW-1:0] ACT_TICK  = 2'd2;

  localparam logic [VerdW-1:0] VERD_REJECT = 2'd0;
  localparam logic [VerdW-1:0] VERD_REFUSE = 2'd1;
  localparam logic [VerdW-1:0] VERD_GRANT  = 2'd2;

  // out_tdata bit positions
  localparam int OutPhaseLsb  = 3;
  localparam int OutReasonLsb = 6;
  localparam int OutOffBit    = 9;
  localparam int OutOkBit     = 10;

  typedef struct packed {
    logic capture;  // item taken from the input channel
    logic commit;   // entry written back and result loaded
  } cmd_t;

  typedef struct packed {
    logic out_free;  // result register can take a new result
  } status_t;

endpackage

### src/cps_ram.sv
// generic single write port ram with registered read
module cps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/cps_ctrl.sv
// controller: accept, then read-modify-write of one channel entry
module cps_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  cps_pkg::status_t  status,
  output cps_pkg::cmd_t     cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r;
  logic state_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign cmd.capture = in_tvalid && in_tready;
  assign cmd.commit  = (state_r == S_EXEC) && status.out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.capture) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### src/cps_dp.sv
// datapath: item register, channel entry ram, phase update and result register
module cps_dp #(
  parameter int CHANNELS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [cps_pkg::InDataW-1:0]   in_tdata,
  input  logic [cps_pkg::ActW-1:0]      in_tuser,
  input  cps_pkg::cmd_t                 cmd,
  output cps_pkg::status_t              status,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [cps_pkg::OutDataW-1:0]  out_tdata
);

  localparam int IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef struct packed {
    logic [cps_pkg::ActW-1:0]   action;
    logic [cps_pkg::SlotW-1:0]  slot;
    logic [cps_pkg::TickW-1:0]  tick_ms;
    logic                       cc_active;
    logic                       output_on;
    logic                       fault;
    logic                       link_lost;
    logic signed [cps_pkg::CurW-1:0] current_ua;
    logic [cps_pkg::VerdW-1:0]  start_verdict;
    logic [cps_pkg::TimeW-1:0]  limit_ms;
    logic [cps_pkg::CutW-1:0]   cutoff_ua;
    logic [cps_pkg::TimeW-1:0]  hold_ms;
  } item_t;

  typedef struct packed {
    logic [cps_pkg::PhaseW-1:0]  phase;
    logic [cps_pkg::ReasonW-1:0] reason;
    logic [cps_pkg::TimeW-1:0]   elapsed;
    logic [cps_pkg::TimeW-1:0]   below;
    logic [cps_pkg::TimeW-1:0]   limit;
    logic [cps_pkg::CutW-1:0]    cutoff;
    logic [cps_pkg::TimeW-1:0]   hold;
  } entry_t;

  item_t  item_r;
  item_t  item_in;
  logic [CHANNELS-1:0] valid_r;
  logic   out_valid_r;
  logic [cps_pkg::OutDataW-1:0] out_data_r;
  logic [cps_pkg::OutDataW-1:0] out_data_nxt;

  logic [31:0]     in_slot_ext;
  logic [31:0]     item_slot_ext;
  logic [IdxW-1:0] in_idx;
  logic [IdxW-1:0] item_idx;
  logic [IdxW-1:0] raddr;
  logic            in_range;
  logic [$bits(entry_t)-1:0] rdata;
  entry_t          cur_e;
  entry_t          new_e;
  logic            off;
  logic            ok;
  logic            we;

  assign item_in.action        = in_tuser;
  assign item_in.slot          = in_tdata[2:0];
  assign item_in.tick_ms       = in_tdata[18:3];
  assign item_in.cc_active     = in_tdata[19];
  assign item_in.output_on     = in_tdata[20];
  assign item_in.fault         = in_tdata[21];
  assign item_in.link_lost     = in_tdata[22];
  assign item_in.current_ua    = in_tdata[54:23];
  assign item_in.start_verdict = in_tdata[56:55];
  assign item_in.limit_ms      = in_tdata[88:57];
  assign item_in.cutoff_ua     = in_tdata[119:89];
  assign item_in.hold_ms       = in_tdata[151:120];

  assign in_slot_ext   = {{(32 - cps_pkg::SlotW){1'b0}}, item_in.slot};
  assign item_slot_ext = {{(32 - cps_pkg::SlotW){1'b0}}, item_r.slot};
  assign in_idx   = in_slot_ext[IdxW-1:0];
  assign item_idx = item_slot_ext[IdxW-1:0];
  assign in_range = (item_slot_ext < CHANNELS);
  assign raddr    = cmd.capture ? in_idx : item_idx;
  assign we       = cmd.commit && in_range;

  cps_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CHANNELS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (item_idx),
    .wdata (new_e),
    .raddr (raddr),
    .rdata (rdata)
  );

  // a channel never written reads as idle with cleared timers
  always_comb begin
    cur_e = rdata;
    if (!valid_r[item_idx]) begin
      cur_e.phase   = cps_pkg::PH_IDLE;
      cur_e.reason  = cps_pkg::RS_NONE;
      cur_e.elapsed = '0;
      cur_e.below   = '0;
    end
  end

  always_comb begin
    logic        active;
    logic [32:0] el_sum;
    logic [31:0] el_sat;
    logic [32:0] bl_sum;
    logic [31:0] bl_sat;
    logic        is_below;

    new_e    = cur_e;
    off      = 1'b0;
    ok       = 1'b0;
    active   = (cur_e.phase == cps_pkg::PH_RAMP) || (cur_e.phase == cps_pkg::PH_CC) ||
               (cur_e.phase == cps_pkg::PH_CV) || (cur_e.phase == cps_pkg::PH_TERM);
    el_sum   = {1'b0, cur_e.elapsed} + {17'b0, item_r.tick_ms};
    el_sat   = el_sum[32] ? '1 : el_sum[31:0];
    bl_sum   = {1'b0, cur_e.below} + {17'b0, item_r.tick_ms};
    bl_sat   = bl_sum[32] ? '1 : bl_sum[31:0];
    // negative current never counts as below the cutoff
    is_below = !item_r.current_ua[31] && (item_r.current_ua[30:0] < cur_e.cutoff);

    unique case (item_r.action)
      cps_pkg::ACT_START: begin
        new_e.limit  = item_r.limit_ms;
        new_e.cutoff = item_r.cutoff_ua;
        new_e.hold   = item_r.hold_ms;
        if (item_r.start_verdict == cps_pkg::VERD_GRANT) begin
          new_e.elapsed = '0;
          new_e.below   = '0;
          new_e.phase   = cps_pkg::PH_RAMP;
          new_e.reason  = cps_pkg::RS_NONE;
          ok            = 1'b1;
        end else if (item_r.start_verdict == cps_pkg::VERD_REFUSE) begin
          new_e.elapsed = '0;
          new_e.below   = '0;
          new_e.reason  = cps_pkg::RS_REFUSED;
        end
      end
      cps_pkg::ACT_ABORT: begin
        if (active) begin
          new_e.phase  = cps_pkg::PH_ABORT;
          new_e.reason = cps_pkg::RS_USER;
          off          = 1'b1;
        end
      end
      cps_pkg::ACT_TICK: begin
        if (active) begin
          new_e.elapsed = el_sat;
          if ((cur_e.limit != '0) && (el_sat > cur_e.limit)) begin
            new_e.phase  = cps_pkg::PH_ABORT;
            new_e.reason = cps_pkg::RS_TIMEOUT;
            off          = 1'b1;
          end else if (item_r.fault) begin
            new_e.phase  = cps_pkg::PH_ABORT;
            new_e.reason = cps_pkg::RS_FAULT;
            off          = 1'b1;
          end else if (item_r.link_lost) begin
            new_e.phase  = cps_pkg::PH_ABORT;
            new_e.reason = cps_pkg::RS_LOST;
            off          = 1'b1;
          end else if (cur_e.phase == cps_pkg::PH_RAMP) begin
            if (item_r.output_on) begin
              new_e.phase = item_r.cc_active ? cps_pkg::PH_CC : cps_pkg::PH_CV;
            end
          end else if (cur_e.phase == cps_pkg::PH_CC) begin
            if (!item_r.cc_active) begin
              new_e.phase = cps_pkg::PH_CV;
            end
          end else if (item_r.cc_active) begin
            new_e.phase = cps_pkg::PH_CC;
            new_e.below = '0;
          end else if (is_below) begin
            new_e.below = bl_sat;
            if (bl_sat >= cur_e.hold) begin
              new_e.phase = cps_pkg::PH_DONE;
              off         = 1'b1;
            end else begin
              new_e.phase = cps_pkg::PH_TERM;
            end
          end else begin
            new_e.phase = cps_pkg::PH_CV;
            new_e.below = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[cps_pkg::SlotW-1:0] = item_r.slot;
    if (in_range) begin
      out_data_nxt[cps_pkg::OutPhaseLsb +: cps_pkg::PhaseW]   = new_e.phase;
      out_data_nxt[cps_pkg::OutReasonLsb +: cps_pkg::ReasonW] = new_e.reason;
      out_data_nxt[cps_pkg::OutOffBit] = off;
      out_data_nxt[cps_pkg::OutOkBit]  = ok;
    end
  end

  assign status.out_free = !out_valid_r || out_tready;
  assign out_tvalid      = out_valid_r;
  assign out_tdata       = out_data_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= item_in;
    end
    if (cmd.commit) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (we) begin
        valid_r[item_idx] <= 1'b1;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

### src/charge_phase_sequencer.sv
// top level of the per-channel cc/cv charge phase sequencer
//
// in_* carries one item per handshake: a start, a user abort or a time tick
// for one channel (action in in_tuser). out_* returns exactly one result item
// for every input item, in order: the channel, its phase and abort reason
// after the item, an output-off request and a start-granted flag.
// Each channel keeps its phase, reason, elapsed and below-cutoff timers and
// its charge profile in one ram entry. The entry is read at the accepting
// edge and written back in the exec state once the output register is free,
// when the result is loaded; the block takes no new item until the previous
// one is written back, as the ram read-modify-write requires.
// The result sits in an output register: in_tready stays high while it
// waits, but a following item is held before write-back until out_tready
// frees the register, and in_tready is low meanwhile.
// Reset clears the per-channel valid bits, so every channel reads as idle
// with cleared timers; there is no clearing pass.
// Slots at or above CHANNELS report idle and change nothing.
module charge_phase_sequencer #(
  parameter int CHANNELS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // slot, tick_ms, cc_active, output_on, fault, link_lost, current_ua,
  // start_verdict, limit_ms, cutoff_ua, hold_ms
  input  logic [cps_pkg::InDataW-1:0]   in_tdata,
  // action
  input  logic [cps_pkg::ActW-1:0]      in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // out_slot, phase, abort_reason, output_off, start_ok, 5 zero bits
  output logic [cps_pkg::OutDataW-1:0]  out_tdata
);

  cps_pkg::cmd_t    cmd;
  cps_pkg::status_t status;

  logic [cps_pkg::PhaseW-1:0]  res_phase;
  logic [cps_pkg::ReasonW-1:0] res_reason;
  logic                        res_fresh;
  logic                        res_final;

  cps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  cps_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  assign res_phase  = out_tdata[cps_pkg::OutPhaseLsb +: cps_pkg::PhaseW];
  assign res_reason = out_tdata[cps_pkg::OutReasonLsb +: cps_pkg::ReasonW];
  assign res_fresh  = (res_phase == cps_pkg::PH_RAMP) && (res_reason == cps_pkg::RS_NONE);
  assign res_final  = (res_phase == cps_pkg::PH_DONE) || (res_phase == cps_pkg::PH_ABORT);

`include "charge_phase_sequencer_macros.svh"

  // a granted start always lands in ramp with no reason
  `CPS_ASSERT_IMP(a_start_ok_ramp, out_tvalid && out_tdata[cps_pkg::OutOkBit], res_fresh)
  // output off only with a finished or aborted charge
  `CPS_ASSERT_IMP(a_off_final, out_tvalid && out_tdata[cps_pkg::OutOffBit], res_final)
  // one write-back per item, never overlapping an accept
  `CPS_ASSERT_NXT(a_commit_once, cmd.commit, !cmd.commit)
  `CPS_ASSERT_IMP(a_no_accept_in_exec, cmd.commit, !cmd.capture)

endmodule

### test/charge_phase_sequencer_tb.sv
// self-checking testbench of the charge phase sequencer, stream in and stream out
module charge_phase_sequencer_tb;
  import cps_pkg::*;

  localparam int STALL_LIMIT = 3000;
  // codes the block must tolerate but does not act on, beyond storing a start's profile
  localparam logic [ActW-1:0]  ACT_NONE     = 2'd3;
  localparam logic [VerdW-1:0] VERD_UNUSED  = 2'd3;

  typedef struct packed {
    logic [ActW-1:0]  action;
    logic [SlotW-1:0] slot;
    logic [TickW-1:0] tick_ms;
    logic             cc_active;
    logic             output_on;
    logic             fault;
    logic             link_lost;
    logic [CurW-1:0]  current_ua;
    logic [VerdW-1:0] verdict;
    logic [TimeW-1:0] limit_ms;
    logic [CutW-1:0]  cutoff_ua;
    logic [TimeW-1:0] hold_ms;
  } charge_item_t;

  typedef struct packed {
    logic [SlotW-1:0]   slot;
    logic [PhaseW-1:0]  phase;
    logic [ReasonW-1:0] reason;
    logic               output_off;
    logic               start_ok;
  } charge_res_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata = '0;
  logic [ActW-1:0]     in_tuser = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;

  // per-channel copy of the sequencer state
  logic [PhaseW-1:0]  chan_phase   [8];
  logic [ReasonW-1:0] chan_reason  [8];
  logic [TimeW-1:0]   chan_elapsed [8];
  logic [TimeW-1:0]   chan_below   [8];
  logic [TimeW-1:0]   chan_limit   [8];
  logic [CutW-1:0]    chan_cutoff  [8];
  logic [TimeW-1:0]   chan_hold    [8];

  charge_res_t expected_results[$];
  int err_cnt = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int recv_hold_left = 0;
  int stall_cycles = 0;

  charge_phase_sequencer #(.CHANNELS(8)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  function automatic logic [TimeW-1:0] sat_sum(logic [TimeW-1:0] a, logic [TimeW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TimeW] ? {TimeW{1'b1}} : s[TimeW-1:0];
  endfunction

  function automatic bit chan_charging(int ch);
    return chan_phase[ch] == PH_RAMP || chan_phase[ch] == PH_CC ||
           chan_phase[ch] == PH_CV || chan_phase[ch] == PH_TERM;
  endfunction

  function automatic charge_res_t predict_charge(charge_item_t it);
    charge_res_t r;
    int ch;
    logic [TimeW-1:0] dt;
    ch = int'(it.slot);
    dt = {16'd0, it.tick_ms};
    r = '0;
    r.slot = it.slot;
    case (it.action)
      ACT_START: begin
        chan_limit[ch]  = it.limit_ms;
        chan_cutoff[ch] = it.cutoff_ua;
        chan_hold[ch]   = it.hold_ms;
        if (it.verdict == VERD_REFUSE || it.verdict == VERD_GRANT) begin
          chan_elapsed[ch] = '0;
          chan_below[ch]   = '0;
          if (it.verdict == VERD_GRANT) begin
            chan_phase[ch]  = PH_RAMP;
            chan_reason[ch] = RS_NONE;
            r.start_ok = 1'b1;
          end else begin
            chan_reason[ch] = RS_REFUSED;
          end
        end
      end
      ACT_ABORT: begin
        if (chan_charging(ch)) begin
          chan_phase[ch]  = PH_ABORT;
          chan_reason[ch] = RS_USER;
          r.output_off = 1'b1;
        end
      end
      ACT_TICK: begin
        if (chan_charging(ch)) begin
          chan_elapsed[ch] = sat_sum(chan_elapsed[ch], dt);
          // timeout beats fault beats lost link
          if (chan_limit[ch] != 0 && chan_elapsed[ch] > chan_limit[ch]) begin
            chan_phase[ch]  = PH_ABORT;
            chan_reason[ch] = RS_TIMEOUT;
            r.output_off = 1'b1;
          end else if (it.fault) begin
            chan_phase[ch]  = PH_ABORT;
            chan_reason[ch] = RS_FAULT;
            r.output_off = 1'b1;
          end else if (it.link_lost) begin
            chan_phase[ch]  = PH_ABORT;
            chan_reason[ch] = RS_LOST;
            r.output_off = 1'b1;
          end else if (chan_phase[ch] == PH_RAMP) begin
            if (it.output_on) chan_phase[ch] = it.cc_active ? PH_CC : PH_CV;
          end else if (chan_phase[ch] == PH_CC) begin
            if (!it.cc_active) chan_phase[ch] = PH_CV;
          end else if (it.cc_active) begin
            chan_phase[ch] = PH_CC;
            chan_below[ch] = '0;
          end else if (!it.current_ua[CurW-1] &&
                       it.current_ua < {1'b0, chan_cutoff[ch]}) begin
            chan_phase[ch] = PH_TERM;
            chan_below[ch] = sat_sum(chan_below[ch], dt);
            if (chan_below[ch] >= chan_hold[ch]) begin
              chan_phase[ch] = PH_DONE;
              r.output_off = 1'b1;
            end
          end else begin
            chan_phase[ch] = PH_CV;
            chan_below[ch] = '0;
          end
        end
      end
      default: ;
    endcase
    r.phase  = chan_phase[ch];
    r.reason = chan_reason[ch];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    if (err_cnt < 100)
      $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $time);
    err_cnt++;
  endtask

  task automatic send_item(charge_item_t it);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = it.action;
    in_tdata  = {it.hold_ms, it.cutoff_ua, it.limit_ms, it.verdict, it.current_ua,
                 it.link_lost, it.fault, it.output_on, it.cc_active, it.tick_ms, it.slot};
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(predict_charge(it));
  endtask

  task automatic send_start(int slot, logic [VerdW-1:0] verdict, logic [TimeW-1:0] limit,
                            logic [CutW-1:0] cutoff, logic [TimeW-1:0] hold);
    charge_item_t it;
    it = '0;
    it.action = ACT_START;
    it.slot = 3'(slot);
    it.verdict = verdict;
    it.limit_ms = limit;
    it.cutoff_ua = cutoff;
    it.hold_ms = hold;
    send_item(it);
  endtask

  task automatic send_tick(int slot, logic [TickW-1:0] dt, logic cc, logic on, logic flt,
                           logic lost, logic [CurW-1:0] cur);
    charge_item_t it;
    it = '0;
    it.action = ACT_TICK;
    it.slot = 3'(slot);
    it.tick_ms = dt;
    it.cc_active = cc;
    it.output_on = on;
    it.fault = flt;
    it.link_lost = lost;
    it.current_ua = cur;
    send_item(it);
  endtask

  task automatic send_cmd(logic [ActW-1:0] act, int slot);
    charge_item_t it;
    it = '0;
    it.action = act;
    it.slot = 3'(slot);
    send_item(it);
  endtask

  function automatic charge_item_t random_item();
    charge_item_t it;
    int pick;
    it = '0;
    pick = $urandom_range(0, 99);
    if (pick < 8)       it.action = ACT_START;
    else if (pick < 12) it.action = ACT_ABORT;
    else if (pick < 14) it.action = ACT_NONE;
    else                it.action = ACT_TICK;
    it.slot = 3'($urandom_range(0, 7));
    it.tick_ms = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
    it.cc_active = ($urandom_range(0, 3) == 0);
    it.output_on = ($urandom_range(0, 9) != 0);
    it.fault = ($urandom_range(0, 49) == 0);
    it.link_lost = ($urandom_range(0, 49) == 0);
    pick = $urandom_range(0, 9);
    if (pick < 5)       it.current_ua = $urandom_range(0, 1500);
    else if (pick < 7)  it.current_ua = $urandom_range(1000, 5000);
    else if (pick < 8)  it.current_ua = 32'hFFFF_FFFF - $urandom_range(0, 1000);
    else                it.current_ua = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 70)      it.verdict = VERD_GRANT;
    else if (pick < 80) it.verdict = VERD_REFUSE;
    else if (pick < 90) it.verdict = VERD_REJECT;
    else                it.verdict = VERD_UNUSED;
    pick = $urandom_range(0, 99);
    if (pick < 30)      it.limit_ms = '0;
    else if (pick < 85) it.limit_ms = $urandom_range(5000, 500000);
    else                it.limit_ms = $urandom;
    it.cutoff_ua = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(500, 1500));
    pick = $urandom_range(0, 99);
    if (pick < 10)      it.hold_ms = '0;
    else if (pick < 85) it.hold_ms = $urandom_range(0, 5000);
    else                it.hold_ms = $urandom;
    return it;
  endfunction

  // results are compared with the oldest expectation
  always @(posedge clk) begin : check_results
    charge_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected", 0, 32'(out_tdata));
      end else begin
        want = expected_results.pop_front();
        if (out_tdata[SlotW-1:0] != want.slot)
          report_mismatch("out_slot", 32'(want.slot), 32'(out_tdata[SlotW-1:0]));
        if (out_tdata[OutPhaseLsb +: PhaseW] != want.phase)
          report_mismatch("phase", 32'(want.phase), 32'(out_tdata[OutPhaseLsb +: PhaseW]));
        if (out_tdata[OutReasonLsb +: ReasonW] != want.reason)
          report_mismatch("abort_reason", 32'(want.reason),
                          32'(out_tdata[OutReasonLsb +: ReasonW]));
        if (out_tdata[OutOffBit] != want.output_off)
          report_mismatch("output_off", 32'(want.output_off), 32'(out_tdata[OutOffBit]));
        if (out_tdata[OutOkBit] != want.start_ok)
          report_mismatch("start_ok", 32'(want.start_ok), 32'(out_tdata[OutOkBit]));
        if (out_tdata[OutDataW-1:OutOkBit+1] != '0)
          report_mismatch("pad bits", 0, 32'(out_tdata[OutDataW-1:OutOkBit+1]));
      end
    end
  end

  // receiver: random idling, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (recv_hold_left > 0) begin
      recv_hold_left--;
      out_tready = 1'b0;
    end else begin
      out_tready = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("** charge_phase_sequencer: FAILED **");
      $finish;
    end
  end

  task automatic test_idle_channels();
    send_tick(0, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1, 32'h8000_0000);
    send_cmd(ACT_ABORT, 0);
    send_cmd(ACT_NONE, 7);
  endtask

  task automatic test_start_verdicts();
    send_start(1, VERD_REJECT, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_start(1, VERD_UNUSED, 32'h0, 31'h0, 32'h0);
    send_start(1, VERD_REFUSE, 32'h0, 31'd1000, 32'd100);
    send_start(1, VERD_GRANT, 32'h0, 31'd1000, 32'd100);
  endtask

  task automatic test_phase_walk();
    send_tick(1, 16'd10, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);      // output still off
    send_tick(1, 16'd10, 1'b1, 1'b1, 1'b0, 1'b0, 32'd0);      // into cc
    send_tick(1, 16'd10, 1'b0, 1'b1, 1'b0, 1'b0, 32'd5000);   // into cv
    send_tick(1, 16'd10, 1'b1, 1'b1, 1'b0, 1'b0, 32'd5000);   // back to cc
    send_tick(1, 16'd10, 1'b0, 1'b1, 1'b0, 1'b0, 32'd5000);
    send_tick(1, 16'd10, 1'b0, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF);  // negative current
    send_tick(1, 16'd60, 1'b0, 1'b1, 1'b0, 1'b0, 32'd500);    // term wait
    send_tick(1, 16'd60, 1'b0, 1'b1, 1'b0, 1'b0, 32'd1000);   // equal to cutoff
    send_tick(1, 16'd100, 1'b0, 1'b1, 1'b0, 1'b0, 32'd999);   // hold reached
    send_tick(1, 16'd10, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0);
    send_cmd(ACT_ABORT, 1);
  endtask

  task automatic test_abort_priority();
    send_start(2, VERD_GRANT, 32'd50, 31'd1000, 32'd100);
    send_tick(2, 16'd51, 1'b0, 1'b1, 1'b1, 1'b1, 32'd0);
    send_start(1, VERD_GRANT, 32'h0, 31'd1000, 32'd100);
    send_tick(1, 16'd5, 1'b0, 1'b1, 1'b1, 1'b1, 32'd0);
    send_start(3, VERD_GRANT, 32'd1000, 31'd1000, 32'd100);
    send_tick(3, 16'd5, 1'b0, 1'b1, 1'b0, 1'b1, 32'd0);
  endtask

  task automatic test_restart_and_user_abort();
    send_start(6, VERD_GRANT, 32'h0, 31'd1000, 32'd100);
    send_tick(6, 16'd5, 1'b1, 1'b1, 1'b0, 1'b0, 32'd0);
    send_start(6, VERD_GRANT, 32'h0, 31'd1000, 32'd100);
    send_cmd(ACT_ABORT, 6);
  endtask

  task automatic test_zero_hold();
    send_start(7, VERD_GRANT, 32'h0, 31'd1, 32'd0);
    send_tick(7, 16'd0, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0);
    send_tick(7, 16'd0, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0);
  endtask

  task automatic test_random(int count, int s_idle, int r_idle);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    repeat (count) send_item(random_item());
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_hold_left = 400;
    repeat (40) send_item(random_item());
  endtask

  // full-size ticks pile up on the elapsed and below-cutoff timers
  task automatic test_large_ticks();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_start(5, VERD_GRANT, 32'h0, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_tick(5, 16'hFFFF, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0);
    send_tick(5, 16'hFFFE, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0);
    repeat (20) send_tick(5, 16'hFFFF, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0);
    send_tick(5, 16'hFFFF, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0);
  endtask

  initial begin
    for (int i = 0; i < 8; i++) begin
      chan_phase[i]   = PH_IDLE;
      chan_reason[i]  = RS_NONE;
      chan_elapsed[i] = '0;
      chan_below[i]   = '0;
      chan_limit[i]   = '0;
      chan_cutoff[i]  = '0;
      chan_hold[i]    = '0;
    end
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    send_idle_pct = 9;
    recv_idle_pct = 59;
    test_idle_channels();
    test_start_verdicts();
    test_phase_walk();
    test_abort_priority();
    test_restart_and_user_abort();
    test_zero_hold();
    test_random(650, 9, 59);
    test_backpressure();
    test_random(650, 59, 9);
    test_random(650, 0, 0);
    test_large_ticks();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("** charge_phase_sequencer: PASSED **");
    end else begin
      $display("** charge_phase_sequencer: FAILED **");
    end
    $finish;
  end

endmodule
